// ----- rtl/core/per_source_ordered_delivery_monitor_defines.svh -----
// Assertion macros used by the checker file of the ordered delivery monitor.
`ifndef PER_SOURCE_ORDERED_DELIVERY_MONITOR_DEFINES_SVH
`define PER_SOURCE_ORDERED_DELIVERY_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PSODM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PSODM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/psodm_pkg.sv -----
`default_nettype none

package psodm_pkg;

  // Default table sizes
  localparam int DefSources   = 64;
  localparam int DefHoldDepth = 8;

  // Fixed field widths
  localparam int KeyWidth    = 48;
  localparam int SeqWidth    = 17;
  localparam int SlotWidth   = 6;
  localparam int CountWidth  = 4;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_IN_ORDER   = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_HELD       = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_HOLD_FULL  = 3'd5
  } status_e;

endpackage

`default_nettype wire

// ----- rtl/core/per_source_ordered_delivery_monitor.sv -----
`default_nettype none
// Per-source ordered delivery monitor (holdback queue).
// Input channel: in_valid_i/in_ready_o carry a 48-bit source key (address:port)
// and a 17-bit sequence number. Output channel: out_valid_o/out_ready_i carry
// exactly one result per input: status, table slot, latest in-order number,
// numbers released from holdback and numbers still held.
// One item is worked on at a time; in_ready_o is high only while idle.
// Steps per item: accept, key search, table read, holdback scan and write.
// The scan for a held or duplicate check stops at a match or after one pass
// over the holdback entries; a drain walks them circularly until a full pass
// finds no next number. The key search walks the source
// table one entry a cycle through a single comparator and the holdback scan
// walks the holdback memory one entry a cycle through a single comparator.
// Reset empties the source table (source count to zero); no memory clear pass
// is needed because only rows below the count are ever read.
// A result waits in the output register while the receiver stalls; the next
// item is accepted and worked on meanwhile, and its write-back waits until
// the output register is free.
module per_source_ordered_delivery_monitor
  import psodm_pkg::*;
#(
  parameter int SOURCES    = DefSources,
  parameter int HOLD_DEPTH = DefHoldDepth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [KeyWidth-1:0]   source_key_i,
  input  wire logic [SeqWidth-1:0]   seq_number_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [2:0]                 status_o,
  output logic [SlotWidth-1:0]       source_slot_o,
  output logic [SeqWidth-1:0]        latest_delivered_o,
  output logic [CountWidth-1:0]      released_count_o,
  output logic [CountWidth-1:0]      held_count_o
);

  localparam int SW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int NW    = $clog2(SOURCES + 1);
  localparam int HW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW    = $clog2(HOLD_DEPTH + 1);
  localparam int HSLOT = 1 << HW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_LOAD   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_SCAN   = 6'b010000,
    S_WRITE  = 6'b100000
  } state_e;

  // Control state
  state_e        state_q, state_d;
  logic [NW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;

  // Working registers
  logic [KeyWidth-1:0]   key_q, key_d;
  logic [SeqWidth-1:0]   seq_q, seq_d;
  logic [NW-1:0]         s_q, s_d;
  logic                  pend_q, pend_d;
  logic [SW-1:0]         pidx_q, pidx_d;
  logic [SW-1:0]         slot_q, slot_d;
  logic [HW-1:0]         h_q, h_d;
  logic [HW-1:0]         ph_q, ph_d;
  logic [CW-1:0]         n_q, n_d;
  logic                  drain_q, drain_d;
  logic [HOLD_DEPTH-1:0] vr_q, vr_d;
  logic [CW-1:0]         hc_q, hc_d;
  logic [CW-1:0]         rel_q, rel_d;
  logic [SeqWidth-1:0]   latest_q, latest_d;
  logic [HW-1:0]         fidx_q, fidx_d;
  logic                  free_q, free_d;
  logic                  hold_wr_q, hold_wr_d;
  logic                  new_q, new_d;
  logic                  upd_q, upd_d;
  status_e               status_q, status_d;

  // Memories and their read registers
  logic [KeyWidth-1:0]   key_mem  [SOURCES];
  logic [SeqWidth-1:0]   lat_mem  [SOURCES];
  logic [HOLD_DEPTH-1:0] vrow_mem [SOURCES];
  logic [CW-1:0]         cnt_mem  [SOURCES];
  logic [SeqWidth-1:0]   held_mem [SOURCES*HSLOT];

  logic [KeyWidth-1:0]   key_rd_q;
  logic [SeqWidth-1:0]   lat_rd_q;
  logic [HOLD_DEPTH-1:0] vrow_rd_q;
  logic [CW-1:0]         cnt_rd_q;
  logic [SeqWidth-1:0]   hd_q;

  // Output register
  status_e               out_status_q;
  logic [SlotWidth-1:0]  out_slot_q;
  logic [SeqWidth-1:0]   out_latest_q;
  logic [CountWidth-1:0] out_rel_q;
  logic [CountWidth-1:0] out_held_q;

  logic                  out_free;
  logic                  out_load;
  logic [SeqWidth:0]     target;
  logic                  hit_h;
  logic                  free_any;
  logic [HW-1:0]         fidx;
  logic [SW+SlotWidth-1:0]  slot_ext;
  logic [CW+CountWidth-1:0] rel_ext;
  logic [CW+CountWidth-1:0] hc_ext;

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign source_slot_o      = out_slot_q;
  assign latest_delivered_o = out_latest_q;
  assign released_count_o   = out_rel_q;
  assign held_count_o       = out_held_q;

  assign out_free = !out_valid_q || out_ready_i;

  // Shared holdback comparator
  assign target   = drain_q ? ({1'b0, latest_q} + {{SeqWidth{1'b0}}, 1'b1}) : {1'b0, seq_q};
  assign hit_h    = pend_q && vr_q[ph_q] && ({1'b0, hd_q} == target);
  assign free_any = free_q || !vr_q[ph_q];
  assign fidx     = free_q ? fidx_q : ph_q;

  // Fit internal widths to the fixed result fields
  assign slot_ext = {{SlotWidth{1'b0}}, slot_q};
  assign rel_ext  = {{CountWidth{1'b0}}, rel_q};
  assign hc_ext   = {{CountWidth{1'b0}}, hc_q};

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    key_d       = key_q;
    seq_d       = seq_q;
    s_d         = s_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    slot_d      = slot_q;
    h_d         = h_q;
    ph_d        = ph_q;
    n_d         = n_q;
    drain_d     = drain_q;
    vr_d        = vr_q;
    hc_d        = hc_q;
    rel_d       = rel_q;
    latest_d    = latest_q;
    fidx_d      = fidx_q;
    free_d      = free_q;
    hold_wr_d   = hold_wr_q;
    new_d       = new_q;
    upd_d       = upd_q;
    status_d    = status_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d     = source_key_i;
          seq_d     = seq_number_i;
          s_d       = '0;
          pend_d    = 1'b0;
          new_d     = 1'b0;
          upd_d     = 1'b0;
          hold_wr_d = 1'b0;
          drain_d   = 1'b0;
          state_d   = S_SEARCH;
        end
      end

      // Walk the source table one key a cycle
      S_SEARCH: begin
        if (pend_q && (key_rd_q == key_q)) begin
          slot_d  = pidx_q;
          state_d = S_LOAD;
        end else if (s_q < count_q) begin
          pidx_d = s_q[SW-1:0];
          pend_d = 1'b1;
          s_d    = s_q + NW'(1);
        end else if (count_q == NW'(SOURCES)) begin
          status_d = ST_TABLE_FULL;
          slot_d   = '0;
          latest_d = '0;
          hc_d     = '0;
          rel_d    = '0;
          state_d  = S_WRITE;
        end else begin
          // Open a new source in the next free slot
          slot_d   = count_q[SW-1:0];
          status_d = ST_NEW;
          new_d    = 1'b1;
          upd_d    = 1'b1;
          rel_d    = '0;
          fidx_d   = '0;
          if (seq_q == SeqWidth'(1)) begin
            latest_d  = SeqWidth'(1);
            vr_d      = '0;
            hc_d      = '0;
            hold_wr_d = 1'b0;
          end else begin
            latest_d  = '0;
            vr_d      = HOLD_DEPTH'(1);
            hc_d      = CW'(1);
            hold_wr_d = 1'b1;
          end
          state_d = S_WRITE;
        end
      end

      S_LOAD: begin
        state_d = S_DECIDE;
      end

      // Classify against the source's latest number
      S_DECIDE: begin
        latest_d = lat_rd_q;
        vr_d     = vrow_rd_q;
        hc_d     = cnt_rd_q;
        rel_d    = '0;
        h_d      = '0;
        pend_d   = 1'b0;
        n_d      = '0;
        free_d   = 1'b0;
        if (seq_q <= lat_rd_q) begin
          status_d = ST_DUPLICATE;
          state_d  = S_WRITE;
        end else if ({1'b0, seq_q} == ({1'b0, lat_rd_q} + {{SeqWidth{1'b0}}, 1'b1})) begin
          latest_d = seq_q;
          status_d = ST_IN_ORDER;
          drain_d  = 1'b1;
          upd_d    = 1'b1;
          state_d  = S_SCAN;
        end else begin
          drain_d = 1'b0;
          state_d = S_SCAN;
        end
      end

      // Walk the holdback entries one a cycle, circularly while draining
      S_SCAN: begin
        ph_d   = h_q;
        pend_d = 1'b1;
        h_d    = (h_q == HW'(HOLD_DEPTH - 1)) ? '0 : h_q + HW'(1);
        if (pend_q) begin
          if (drain_q) begin
            if (hit_h) begin
              vr_d[ph_q] = 1'b0;
              latest_d   = latest_q + SeqWidth'(1);
              rel_d      = rel_q + CW'(1);
              hc_d       = hc_q - CW'(1);
              n_d        = '0;
            end else if (n_q == CW'(HOLD_DEPTH - 1)) begin
              state_d = S_WRITE;
            end else begin
              n_d = n_q + CW'(1);
            end
          end else begin
            if (hit_h) begin
              status_d = ST_DUPLICATE;
              state_d  = S_WRITE;
            end else if (n_q == CW'(HOLD_DEPTH - 1)) begin
              if (free_any) begin
                vr_d[fidx] = 1'b1;
                hc_d       = hc_q + CW'(1);
                fidx_d     = fidx;
                hold_wr_d  = 1'b1;
                upd_d      = 1'b1;
                status_d   = ST_HELD;
              end else begin
                status_d = ST_HOLD_FULL;
              end
              state_d = S_WRITE;
            end else begin
              n_d = n_q + CW'(1);
              if (!vr_q[ph_q] && !free_q) begin
                free_d = 1'b1;
                fidx_d = ph_q;
              end
            end
          end
        end
      end

      // Commit once the output register is free
      S_WRITE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (new_q) begin
            count_d = count_q + NW'(1);
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    seq_q     <= seq_d;
    s_q       <= s_d;
    pend_q    <= pend_d;
    pidx_q    <= pidx_d;
    slot_q    <= slot_d;
    h_q       <= h_d;
    ph_q      <= ph_d;
    n_q       <= n_d;
    drain_q   <= drain_d;
    vr_q      <= vr_d;
    hc_q      <= hc_d;
    rel_q     <= rel_d;
    latest_q  <= latest_d;
    fidx_q    <= fidx_d;
    free_q    <= free_d;
    hold_wr_q <= hold_wr_d;
    new_q     <= new_d;
    upd_q     <= upd_d;
    status_q  <= status_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_slot_q   <= slot_ext[SlotWidth-1:0];
      out_latest_q <= latest_q;
      out_rel_q    <= rel_ext[CountWidth-1:0];
      out_held_q   <= hc_ext[CountWidth-1:0];
    end
  end

  // Table writes
  always_ff @(posedge clk_i) begin
    if ((state_q == S_WRITE) && out_free) begin
      if (new_q) begin
        key_mem[slot_q] <= key_q;
      end
      if (upd_q) begin
        lat_mem[slot_q]  <= latest_q;
        vrow_mem[slot_q] <= vr_q;
        cnt_mem[slot_q]  <= hc_q;
      end
      if (hold_wr_q) begin
        held_mem[{slot_q, fidx_q}] <= seq_q;
      end
    end
  end

  // Registered table reads
  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[s_q[SW-1:0]];
    lat_rd_q  <= lat_mem[slot_q];
    vrow_rd_q <= vrow_mem[slot_q];
    cnt_rd_q  <= cnt_mem[slot_q];
    hd_q      <= held_mem[{slot_q, h_q}];
  end

endmodule

`default_nettype wire

// ----- rtl/core/psodm_checker.sv -----
`default_nettype none
`include "per_source_ordered_delivery_monitor_defines.svh"

module psodm_checker
  import psodm_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [2:0]            status_o,
  input wire logic [SlotWidth-1:0]  source_slot_o,
  input wire logic [SeqWidth-1:0]   latest_delivered_o,
  input wire logic [CountWidth-1:0] released_count_o,
  input wire logic [CountWidth-1:0] held_count_o
);

  // A full table reports nothing but its status
  `PSODM_ASSERT(a_tfull_zero, out_valid_o && (status_o == ST_TABLE_FULL), (source_slot_o == '0) && (latest_delivered_o == '0) && (released_count_o == '0) && (held_count_o == '0), "table full result carries data")

  // Only an in-order number releases held numbers
  `PSODM_ASSERT(a_rel_in_order, out_valid_o && (status_o != ST_IN_ORDER), released_count_o == '0, "release outside in-order result")

  // A new source either starts at one or holds its single number
  `PSODM_ASSERT(a_new_shape, out_valid_o && (status_o == ST_NEW), ((latest_delivered_o == 17'd1) && (held_count_o == 4'd0)) || ((latest_delivered_o == 17'd0) && (held_count_o == 4'd1)), "bad new source result")

  // Hold a stalled result
  `PSODM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(latest_delivered_o) && $stable(held_count_o), "stalled result changed")

endmodule

bind per_source_ordered_delivery_monitor psodm_checker u_psodm_checker (.*);

`default_nettype wire
